>>> rtl/rcpwm_pkg.sv
// Shared types, register indexes and constants of the RC pulse width capture block.
package rcpwm_pkg;

  // Kind of an input transaction, carried on tuser.
  typedef enum logic {
    FUNC_EDGE = 1'b0,
    FUNC_READ = 1'b1
  } func_e_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DEADBAND  = 3'd0,
    REG_MIN_PULSE = 3'd1,
    REG_MAX_PULSE = 3'd2,
    REG_LOSS_TMO  = 3'd3,
    REG_BOOT      = 3'd4,
    REG_QUIET_GAP = 3'd5
  } cfg_reg_e_t;

  localparam int CH_W    = 3;
  localparam int WIDTH_W = 12;
  localparam int TIME_W  = 32;
  localparam int VALUE_W = 11;
  localparam int CFG_W   = 32;

  localparam logic [5:0]         DEADBAND_RST   = 6'd4;
  localparam logic [5:0]         DEADBAND_DFLT  = 6'd4;
  localparam logic [11:0]        MIN_PULSE_RST  = 12'd850;
  localparam logic [11:0]        MAX_PULSE_RST  = 12'd2150;
  localparam logic [23:0]        LOSS_TMO_RST   = 24'd600000;
  localparam logic [31:0]        BOOT_GRACE_RST = 32'd3000000;
  localparam logic [15:0]        QUIET_GAP_RST  = 16'd2500;
  localparam logic [WIDTH_W-1:0] CLAMP_LO       = 12'd1000;
  localparam logic [WIDTH_W-1:0] CLAMP_HI       = 12'd2000;
  localparam int                 RING_LEN       = 3;

  // Per-channel state held in one memory word.
  typedef struct packed {
    logic [TIME_W-1:0]                 start_time;
    logic [RING_LEN-1:0][WIDTH_W-1:0]  ring;
    logic [1:0]                        slot;
    logic [WIDTH_W-1:0]                filtered;
    logic [WIDTH_W-1:0]                held;
  } chan_entry_t;

  // One result transaction, first field in the highest bits.
  typedef struct packed {
    logic                quiet;
    logic                lost;
    logic [WIDTH_W-1:0]  median;
    logic [VALUE_W-1:0]  value;
  } result_t;

  function automatic logic [WIDTH_W-1:0] med3(input logic [WIDTH_W-1:0] a,
                                               input logic [WIDTH_W-1:0] b,
                                               input logic [WIDTH_W-1:0] c);
    logic [WIDTH_W-1:0] m;
    if (a > b) begin
      if (b > c) m = b;
      else m = (a > c) ? c : a;
    end else begin
      if (a > c) m = a;
      else m = (b > c) ? c : b;
    end
    return m;
  endfunction

endpackage

>>> rtl/rc_pwm_channel_capture.sv
// RC servo pulse width capture: edge events in, per-channel filtered width reads out.
//
// Every input transaction is either a timestamped pin edge on a channel (tuser = 0) or a read
// request (tuser = 1); one transaction is taken per clock cycle while ready. Per-channel
// state (start time, three-entry median ring, filtered and held width) lives in a memory with
// a registered read port: a transaction reads its channel's word in the cycle it is accepted,
// and the next cycle computes the width, median and deadband update and writes the word back.
// A transaction that follows one on the same channel gets the fresh word by forwarding, so no
// bubble is needed. A read request's result enters a four-entry result queue at the clock edge
// after acceptance, and the output presents it from the head of that queue.
// tready drops only when that queue would fill, so a stalled output side holds off input after
// a few results. Edge events produce no result. After reset the block is ready at once:
// per-channel valid bits make unwritten words read as zero.
module rc_pwm_channel_capture
  import rcpwm_pkg::*;
#(
  parameter int NUM_CHANNELS = 5
) (
  input  logic              clk,
  input  logic              rst,
  // Input stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,   // channel[2:0], level[3], now_us[35:4], zero fill
  input  logic              s_tuser,   // func
  // Result stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // channel_value[10:0], median_value[22:11],
                                       // signal_lost[23], quiet[24], zero fill
  // Configuration write port.
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Configuration registers.
  logic [5:0]  deadband_us;
  logic [11:0] min_pulse_us;
  logic [11:0] max_pulse_us;
  logic [23:0] loss_timeout_us;
  logic [31:0] boot_grace_us;
  logic [15:0] quiet_gap_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_us     <= DEADBAND_RST;
      min_pulse_us    <= MIN_PULSE_RST;
      max_pulse_us    <= MAX_PULSE_RST;
      loss_timeout_us <= LOSS_TMO_RST;
      boot_grace_us   <= BOOT_GRACE_RST;
      quiet_gap_us    <= QUIET_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e_t'(cfg_addr))
        REG_DEADBAND:  deadband_us     <= cfg_wdata[5:0];
        REG_MIN_PULSE: min_pulse_us    <= cfg_wdata[11:0];
        REG_MAX_PULSE: max_pulse_us    <= cfg_wdata[11:0];
        REG_LOSS_TMO:  loss_timeout_us <= cfg_wdata[23:0];
        REG_BOOT:      boot_grace_us   <= cfg_wdata;
        REG_QUIET_GAP: quiet_gap_us    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Input decode.
  logic [CH_W-1:0]   in_ch;
  logic              in_level;
  logic [TIME_W-1:0] in_now;
  logic              in_ch_ok;
  logic [AW-1:0]     in_addr;
  logic              accept;

  assign in_ch    = s_tdata[2:0];
  assign in_level = s_tdata[3];
  assign in_now   = s_tdata[35:4];
  assign in_ch_ok = 32'(in_ch) < NUM_CHANNELS;
  assign in_addr  = AW'(in_ch);
  assign accept   = s_tvalid && s_tready;

  // Compute stage registers.
  logic              s1_valid;
  func_e_t           s1_func;
  logic              s1_ch_ok;
  logic [AW-1:0]     s1_addr;
  logic              s1_level;
  logic [TIME_W-1:0] s1_now;

  // Channel state memory.
  chan_entry_t              mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  mem_vld;
  chan_entry_t              rd_q;
  logic                     rd_vld;
  logic                     fwd;
  chan_entry_t              fwd_entry;

  chan_entry_t       cur;
  chan_entry_t       nxt;
  logic              mem_we;
  logic              pulse_ok;
  logic [TIME_W-1:0] pulse_w;
  logic [1:0]        slot;
  logic              ring_empty;
  logic [WIDTH_W-1:0] med;
  logic [WIDTH_W-1:0] diff;
  logic [5:0]        db;

  logic [TIME_W-1:0] last_valid_time;

  assign mem_we = s1_valid && (s1_func == FUNC_EDGE) && s1_ch_ok;

  always_ff @(posedge clk) begin
    if (accept && in_ch_ok) begin
      rd_q <= mem[in_addr];
    end
    if (accept) begin
      rd_vld    <= mem_vld[in_addr];
      fwd       <= mem_we && (s1_addr == in_addr);
      fwd_entry <= nxt;
    end
    if (mem_we) begin
      mem[s1_addr] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (mem_we) begin
      mem_vld[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_func  <= func_e_t'(s_tuser);
      s1_ch_ok <= in_ch_ok;
      s1_addr  <= in_addr;
      s1_level <= in_level;
      s1_now   <= in_now;
    end
  end

  // Edge event update of the channel word.
  always_comb begin
    cur        = fwd ? fwd_entry : (rd_vld ? rd_q : '0);
    nxt        = cur;
    pulse_ok   = 1'b0;
    pulse_w    = s1_now - cur.start_time;
    slot       = (cur.slot == 2'd3) ? 2'd0 : cur.slot;
    ring_empty = 1'b0;
    med        = '0;
    diff       = '0;
    db         = (deadband_us != '0) ? deadband_us : DEADBAND_DFLT;
    if (s1_level) begin
      nxt.start_time = s1_now;
    end else if (cur.start_time != '0) begin
      nxt.start_time = '0;
      if (pulse_w >= 32'(min_pulse_us) && pulse_w <= 32'(max_pulse_us)) begin
        pulse_ok       = 1'b1;
        nxt.ring[slot] = pulse_w[WIDTH_W-1:0];
        nxt.slot       = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
        for (int i = 0; i < RING_LEN; i++) begin
          if (nxt.ring[i] == '0) ring_empty = 1'b1;
        end
        // Until the ring is filled the new width bypasses the median.
        med          = ring_empty ? pulse_w[WIDTH_W-1:0]
                                  : med3(nxt.ring[0], nxt.ring[1], nxt.ring[2]);
        nxt.filtered = med;
        diff         = (med >= cur.held) ? med - cur.held : cur.held - med;
        if (cur.held == '0 || diff >= 12'(db)) begin
          nxt.held = med;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid_time <= '0;
    end else if (mem_we && pulse_ok) begin
      last_valid_time <= s1_now;
    end
  end

  // Read request result.
  result_t           res;
  logic [TIME_W-1:0] since;
  logic [WIDTH_W-1:0] held_clamped;

  always_comb begin
    since        = s1_now - last_valid_time;
    res          = '0;
    held_clamped = cur.held;
    if (held_clamped < CLAMP_LO) held_clamped = CLAMP_LO;
    if (held_clamped > CLAMP_HI) held_clamped = CLAMP_HI;
    if (last_valid_time == '0) begin
      res.lost  = s1_now > boot_grace_us;
      res.quiet = 1'b1;
    end else begin
      res.lost  = since > 32'(loss_timeout_us);
      res.quiet = res.lost || since >= 32'(quiet_gap_us);
    end
    if (s1_ch_ok) begin
      res.median = cur.filtered;
      if (!res.lost && cur.held != '0) begin
        res.value = held_clamped[VALUE_W-1:0];
      end
    end
  end

  // Result queue.
  result_t           q_mem [QDEPTH];
  logic [QAW-1:0]    q_wr;
  logic [QAW-1:0]    q_rd;
  logic [QAW:0]      q_count;
  logic              push;
  logic              pop;
  logic              s1_is_read;

  assign s1_is_read = s1_valid && (s1_func == FUNC_READ);
  assign push       = s1_is_read;
  assign pop        = m_tvalid && m_tready;
  assign m_tvalid   = q_count != '0;
  assign m_tdata    = {7'b0, q_mem[q_rd]};
  // Room is kept for the result still in the compute stage and the one about to enter.
  assign s_tready   = (q_count + (QAW+1)'(s1_is_read)) < (QAW+1)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (push) q_wr <= q_wr + QAW'(1);
      if (pop)  q_rd <= q_rd + QAW'(1);
      if (push && !pop) q_count <= q_count + (QAW+1)'(1);
      else if (!push && pop) q_count <= q_count - (QAW+1)'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && q_count == (QAW+1)'(QDEPTH)))
    else $error("result queue overflow");

  a_read_gives_result : assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == FUNC_READ) |=> push)
    else $error("read request produced no result");

  a_edge_no_result : assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == FUNC_EDGE) |=> !push)
    else $error("edge event produced a result");
`endif

endmodule
